// ===== src/mse_pkg.sv =====
package mse_pkg;

    // Control states of the sort engine.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MERGE,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

endpackage

// ===== src/mse_ram.sv =====
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== src/merge_sort_engine_unit.sv =====
// Block sorter. Values enter one per transaction on the input channel; the transaction
// with last set closes the block. The block (up to MAX_ITEMS values; values beyond that
// are dropped, the closing one too) is then sorted in ascending signed order by a
// bottom-up merge sort that ping-pongs between two RAMs, and the sorted values leave
// one per transaction, the final one with last_res set. Loading accepts one value per
// cycle while the sorter is idle. Each merge pass writes one value per cycle, with a
// setup step per merged run, and there are ceil(log2(n)) passes; the output side then
// does a RAM read and an output register load per value, the load waiting while the
// output register is held. The merge loop is bound by its single read/compare/write
// path. New input is taken once the last sorted value sits in the output register, so
// loading the next block overlaps its delivery.
module merge_sort_engine_unit
    import mse_pkg::*;
#(
    parameter int MAX_ITEMS  = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic                         last,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic signed [VALUE_BITS-1:0] value_res,
    output logic                         last_res
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 2;

    state_t state_reg, state_next;

    logic [CW-1:0]         count_reg, count_next;
    logic [SW-1:0]         width_reg, width_next;
    logic [CW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         mid_reg, mid_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic [CW-1:0]         i_reg, i_next;
    logic [CW-1:0]         j_reg, j_next;
    logic [CW-1:0]         k_reg, k_next;
    logic [CW-1:0]         e_reg, e_next;
    logic                  sel_reg, sel_next;
    logic                  res_valid_reg, res_valid_next;
    logic [VALUE_BITS-1:0] value_res_reg, value_res_next;
    logic                  last_res_reg, last_res_next;

    logic                  in_accept;
    logic                  has_room;
    logic [CW-1:0]         count_inc;
    logic [CW-1:0]         block_n;

    logic [SW-1:0]         mid_sum;
    logic [SW-1:0]         hi_sum;
    logic [SW-1:0]         n_ext;
    logic [CW-1:0]         mid_calc;
    logic [CW-1:0]         hi_calc;
    logic [SW-1:0]         width_dbl;

    logic [VALUE_BITS-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
    logic [VALUE_BITS-1:0] src_a, src_b;
    logic                  take_a;
    logic [CW-1:0]         k_inc;
    logic                  run_done;
    logic                  pass_done;
    logic                  sort_done;
    logic                  out_free;
    logic                  emit_last;

    logic [CW-1:0]         raddr_a, raddr_b;
    logic                  we0, we1;
    logic [CW-1:0]         waddr0, waddr1;
    logic [VALUE_BITS-1:0] wdata0, wdata1;

    // Ping-pong memories: mem0 also receives the incoming block.
    mse_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_mem0 (
        .clk     (clk),
        .we      (we0),
        .waddr   (waddr0[AW-1:0]),
        .wdata   (wdata0),
        .raddr_a (raddr_a[AW-1:0]),
        .raddr_b (raddr_b[AW-1:0]),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    mse_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_mem1 (
        .clk     (clk),
        .we      (we1),
        .waddr   (waddr1[AW-1:0]),
        .wdata   (wdata1),
        .raddr_a (raddr_a[AW-1:0]),
        .raddr_b (raddr_b[AW-1:0]),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    // Port side handshakes.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign res_valid = res_valid_reg;
    assign value_res = value_res_reg;
    assign last_res  = last_res_reg;
    assign out_free  = !res_valid_reg || !res_stall;

    // Load bookkeeping: values beyond capacity are dropped.
    assign has_room  = (count_reg < CW'(MAX_ITEMS));
    assign count_inc = count_reg + CW'(1);
    assign block_n   = has_room ? count_inc : count_reg;

    // Run bounds, clipped to the block length.
    assign n_ext     = SW'(count_reg);
    assign mid_sum   = SW'(lo_reg) + width_reg;
    assign hi_sum    = SW'(lo_reg) + (width_reg << 1);
    assign mid_calc  = (mid_sum < n_ext) ? mid_sum[CW-1:0] : count_reg;
    assign hi_calc   = (hi_sum < n_ext) ? hi_sum[CW-1:0] : count_reg;
    assign width_dbl = width_reg << 1;

    // Merge decision on the two run heads read from the source memory.
    assign src_a     = sel_reg ? rd1_a : rd0_a;
    assign src_b     = sel_reg ? rd1_b : rd0_b;
    assign take_a    = (i_reg < mid_reg) &&
                       ((j_reg >= hi_reg) || ($signed(src_a) <= $signed(src_b)));
    assign k_inc     = k_reg + CW'(1);
    assign run_done  = (k_inc == hi_reg);
    assign pass_done = run_done && (hi_reg == count_reg);
    assign sort_done = pass_done && (width_dbl >= n_ext);
    assign emit_last = ((e_reg + CW'(1)) == count_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && last)
                begin
                    state_next = (block_n == CW'(1)) ? ST_EMIT_RD : ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (sort_done)
                begin
                    state_next = ST_EMIT_RD;
                end
                else if (run_done)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and memory accesses.
    always_comb
    begin
        count_next     = count_reg;
        width_next     = width_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        e_next         = e_reg;
        sel_next       = sel_reg;
        res_valid_next = res_valid_reg;
        value_res_next = value_res_reg;
        last_res_next  = last_res_reg;
        raddr_a        = i_reg;
        raddr_b        = j_reg;
        we0            = 1'b0;
        we1            = 1'b0;
        waddr0         = count_reg;
        waddr1         = k_reg;
        wdata0         = value;
        wdata1         = take_a ? src_a : src_b;

        // The output register empties when its transaction completes.
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    we0        = has_room;
                    count_next = block_n;
                    if (last)
                    begin
                        width_next = SW'(1);
                        lo_next    = '0;
                        sel_next   = 1'b0;
                        e_next     = '0;
                    end
                end
            end
            ST_SETUP:
            begin
                // Prime both run heads.
                mid_next = mid_calc;
                hi_next  = hi_calc;
                i_next   = lo_reg;
                j_next   = mid_calc;
                k_next   = lo_reg;
                raddr_a  = lo_reg;
                raddr_b  = mid_calc;
            end
            ST_MERGE:
            begin
                // Write the smaller head to the destination and fetch its successor.
                we0    = sel_reg;
                we1    = !sel_reg;
                waddr0 = k_reg;
                wdata0 = take_a ? src_a : src_b;
                if (take_a)
                begin
                    i_next  = i_reg + CW'(1);
                    raddr_a = i_reg + CW'(1);
                end
                else
                begin
                    j_next  = j_reg + CW'(1);
                    raddr_b = j_reg + CW'(1);
                end
                k_next = k_inc;
                if (run_done)
                begin
                    lo_next = hi_reg;
                    if (pass_done)
                    begin
                        lo_next    = '0;
                        sel_next   = !sel_reg;
                        width_next = width_dbl;
                    end
                end
            end
            ST_EMIT_RD:
            begin
                raddr_a = e_reg;
            end
            ST_EMIT_WR:
            begin
                raddr_a = e_reg;
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    value_res_next = src_a;
                    last_res_next  = emit_last;
                    e_next         = e_reg + CW'(1);
                    if (emit_last)
                    begin
                        count_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            sel_reg       <= sel_next;
        end
    end

    // Work and payload registers.
    always_ff @(posedge clk)
    begin
        width_reg     <= width_next;
        lo_reg        <= lo_next;
        mid_reg       <= mid_next;
        hi_reg        <= hi_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        e_reg         <= e_next;
        value_res_reg <= value_res_next;
        last_res_reg  <= last_res_next;
    end

endmodule

// ===== dv/tb_merge_sort_engine_unit.sv =====
`timescale 1ns / 1ps

module tb_merge_sort_engine_unit;

    localparam int MAX_ITEMS  = 32;
    localparam int VALUE_BITS = 32;
    localparam int RANDOM_ITEMS = 470;
    localparam int IDLE_PCT = 35;
    localparam int CALM_LO = 150;
    localparam int CALM_HI = 260;
    localparam int PRINT_CAP = 40;

    localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        logic                         last;
    } sort_word_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [VALUE_BITS-1:0] value = '0;
    logic                         last = 1'b0;
    logic                         res_valid;
    logic                         res_stall = 1'b1;
    logic signed [VALUE_BITS-1:0] value_res;
    logic                         last_res;

    // Values waiting to be sent, and sorted words the block should return.
    sort_word_t pending_values[$];
    sort_word_t sorted_words[$];

    // Predictor state: the values of the block that is still open.
    logic signed [VALUE_BITS-1:0] open_block[MAX_ITEMS];
    int open_count = 0;

    int mismatch_count = 0;
    int values_accepted = 0;
    int results_seen = 0;

    merge_sort_engine_unit #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .last      (last),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .value_res (value_res),
        .last_res  (last_res)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Store an accepted value; on the closing value, sort the block and queue its words.
    // Values past MAX_ITEMS are dropped, the closing one included.
    task automatic absorb_value(input logic signed [VALUE_BITS-1:0] v, input logic is_last);
        logic signed [VALUE_BITS-1:0] key;
        sort_word_t word;
        int j;
        if (open_count < MAX_ITEMS)
        begin
            open_block[open_count] = v;
            open_count++;
        end
        if (is_last)
        begin
            // Insertion sort, ascending signed order.
            for (int i = 1; i < open_count; i++)
            begin
                key = open_block[i];
                j = i - 1;
                while (j >= 0 && open_block[j] > key)
                begin
                    open_block[j + 1] = open_block[j];
                    j--;
                end
                open_block[j + 1] = key;
            end
            for (int i = 0; i < open_count; i++)
            begin
                word.value = open_block[i];
                word.last = (i == open_count - 1);
                sorted_words.push_back(word);
            end
            open_count = 0;
        end
    endtask

    task automatic queue_value(input logic signed [VALUE_BITS-1:0] v, input logic is_last);
        sort_word_t word;
        word.value = v;
        word.last = is_last;
        pending_values.push_back(word);
    endtask

    // Random block: length mostly short, sometimes full, now and then overflowing.
    task automatic queue_random_block(output int n);
        int r;
        int flavor;
        logic signed [VALUE_BITS-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 50)
            n = $urandom_range(1, 8);
        else if (r < 80)
            n = $urandom_range(9, 16);
        else if (r < 89)
            n = $urandom_range(17, 31);
        else if (r < 94)
            n = MAX_ITEMS;
        else
            n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
        flavor = $urandom_range(0, 9);
        for (int i = 0; i < n; i++)
        begin
            case (flavor)
                0, 1:
                    v = $signed($urandom_range(0, 8)) - 4;
                2:
                begin
                    case ($urandom_range(0, 3))
                        0: v = VAL_MIN;
                        1: v = VAL_MAX;
                        2: v = '0;
                        default: v = '1;
                    endcase
                end
                default:
                    v = $urandom();
            endcase
            queue_value(v, i == n - 1);
        end
    endtask

    // Driver: offers the next pending value, holding it steady while stalled.
    always @(posedge clk)
    begin : driver_blk
        sort_word_t word;
        logic calm;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value <= '0;
            last <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                absorb_value(value, last);
                values_accepted++;
            end
            calm = (values_accepted >= CALM_LO) && (values_accepted < CALM_HI);
            if (pending_values.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                word = pending_values.pop_front();
                in_valid <= 1'b1;
                value <= word.value;
                last <= word.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: checks each accepted result against the oldest sorted word.
    always @(posedge clk)
    begin : monitor_blk
        sort_word_t want;
        logic calm;
        if (rst_n && res_valid && !res_stall)
        begin
            if (sorted_words.size() == 0)
                report_mismatch($sformatf("unexpected result value=%0d last=%0b",
                                          value_res, last_res));
            else
            begin
                want = sorted_words.pop_front();
                if (value_res !== want.value)
                    report_mismatch($sformatf("result %0d: value %0d, expected %0d",
                                              results_seen, value_res, want.value));
                if (last_res !== want.last)
                    report_mismatch($sformatf("result %0d: last %0b, expected %0b",
                                              results_seen, last_res, want.last));
            end
            results_seen++;
        end
        calm = (results_seen >= CALM_LO) && (results_seen < CALM_HI);
        res_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Stimulus and end of run.
    initial
    begin : main_blk
        int random_sent;
        int n;
        // Single-value blocks at both extremes.
        queue_value(VAL_MIN, 1'b1);
        queue_value(VAL_MAX, 1'b1);
        // Two values, reversed extremes.
        queue_value(VAL_MAX, 1'b0);
        queue_value(VAL_MIN, 1'b1);
        // Mixed block with equal values, zero and minus one.
        queue_value('0, 1'b0);
        queue_value('1, 1'b0);
        queue_value(1, 1'b0);
        queue_value(VAL_MAX, 1'b0);
        queue_value(VAL_MIN, 1'b0);
        queue_value(5, 1'b0);
        queue_value(5, 1'b0);
        queue_value('1, 1'b1);
        // Alternating bit patterns and repeats.
        queue_value(32'h5555_5555, 1'b0);
        queue_value(32'hAAAA_AAAA, 1'b0);
        queue_value(3, 1'b0);
        queue_value(3, 1'b0);
        queue_value(3, 1'b1);
        // Strictly descending block.
        for (int i = 6; i >= 1; i--)
            queue_value(i, i == 1);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            queue_random_block(n);
            random_sent += n;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_values.size() != 0 || in_valid)
            @(negedge clk);
        while (sorted_words.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);

        if (sorted_words.size() != 0)
            report_mismatch($sformatf("%0d sorted words never arrived",
                                      sorted_words.size()));
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
